[hw/rtl/gss_pkg.sv]
package gss_pkg;

  localparam int unsigned ScalarW = 256;
  localparam int unsigned LimbW   = 64;
  localparam int unsigned HalfW   = 128;
  // signed working width for the exact halves (|k1|, |k2| < 2^128)
  localparam int unsigned SplitW  = 130;
  // rounded quotients c1, c2 stay below 2^129
  localparam int unsigned QuotW   = 129;

  localparam logic [ScalarW-1:0] OrderN =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;
  localparam logic [ScalarW-1:0] G1 =
    256'h3086D221_A7D46BCD_E86C90E4_9284EB15_3DAA8A14_71E8CA7F_E893209A_45DBB031;
  localparam logic [ScalarW-1:0] G2 =
    256'hE4437ED6_010E8828_6F547FA9_0ABFE4C4_221208AC_9DF506C6_1571B4AE_8AC47F71;

  // lattice basis: a1 + b1*lambda = 0, a2 + b2*lambda = 0 (mod n), b2 = a1
  localparam logic [127:0] MinusB1 = 128'hE4437ED6_010E8828_6F547FA9_0ABFE4C3;
  localparam logic [127:0] A1      = 128'h3086D221_A7D46BCD_E86C90E4_9284EB15;
  localparam logic [128:0] A2      = 129'h1_14CA50F7_A8E2F3F6_57C1108D_9D44CFD8;

endpackage

[hw/rtl/gss_mul.sv]
// Pipelined multiplier built from 32x32 partial products and a registered
// adder tree over the rows. NA >= 2.
module gss_mul #(
  parameter int unsigned NA = 8,
  parameter int unsigned NB = 8,
  parameter int unsigned SW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [32*NA-1:0]         a_i,
  input  logic [32*NB-1:0]         b_i,
  input  logic [SW-1:0]            side_i,
  output logic                     valid_o,
  output logic [32*(NA+NB)-1:0]    prod_o,
  output logic [SW-1:0]            side_o
);

  localparam int unsigned Lvl = $clog2(NA);
  localparam int unsigned NR  = 1 << Lvl;
  localparam int unsigned PW  = 32 * (NA + NB);
  localparam int unsigned Lat = Lvl + 2;

  logic [63:0]   pp_q   [NA][NB];
  logic [PW-1:0] row_d  [NR];
  logic [PW-1:0] lv_q   [Lvl+1][NR];
  logic [Lat-1:0] vld_q;
  logic [SW-1:0] side_q [Lat];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= 64'(a_i[32*i +: 32]) * 64'(b_i[32*j +: 32]);
      end
    end
  end

  // even and odd columns of a row never overlap, so one add per row
  always_comb begin
    logic [PW-1:0] ev;
    logic [PW-1:0] od;
    for (int i = 0; i < NR; i++) begin
      row_d[i] = '0;
    end
    for (int i = 0; i < NA; i++) begin
      ev = '0;
      od = '0;
      for (int j = 0; j < NB; j++) begin
        if (j % 2 == 0) begin
          ev = ev | (PW'(pp_q[i][j]) << (32 * (i + j)));
        end else begin
          od = od | (PW'(pp_q[i][j]) << (32 * (i + j)));
        end
      end
      row_d[i] = ev + od;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < NR; m++) begin
      lv_q[0][m] <= row_d[m];
    end
    for (int l = 0; l < Lvl; l++) begin
      for (int m = 0; m < NR; m++) begin
        if (m < (NR >> (l + 1))) begin
          lv_q[l+1][m] <= lv_q[l][2*m] + lv_q[l][2*m+1];
        end else begin
          lv_q[l+1][m] <= '0;
        end
      end
    end
    side_q[0] <= side_i;
    for (int s = 1; s < Lat; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Lat-1];
  assign prod_o  = lv_q[Lvl][0];
  assign side_o  = side_q[Lat-1];

endmodule

[hw/rtl/glv_scalar_split.sv]
// Channel  | Handshake         | Payload
// ---------+-------------------+-----------------------------------------------
// scalar   | start_i & !busy_o | scalar_limb0_i .. scalar_limb3_i
// result   | done_o (1 cycle)  | first_half_*_o, second_half_*_o
//
// Fully pipelined: one scalar may enter every cycle.
// A scalar passes the reduce stage, a multiplier tree, the rounding stage, a
// second multiplier tree, the combine and output stages. busy_o is always low.
// Reset clears only the valid bits; the receiver cannot stall, so nothing does.
module glv_scalar_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] scalar_limb0_i,
  input  logic [63:0] scalar_limb1_i,
  input  logic [63:0] scalar_limb2_i,
  input  logic [63:0] scalar_limb3_i,
  output logic        done_o,
  output logic [63:0] first_half_low_o,
  output logic [63:0] first_half_high_o,
  output logic        first_half_negative_o,
  output logic [63:0] second_half_low_o,
  output logic [63:0] second_half_high_o,
  output logic        second_half_negative_o
);

  localparam int unsigned SW = gss_pkg::SplitW;
  localparam int unsigned QW = gss_pkg::QuotW;

  logic [255:0] k_in;
  logic [255:0] k_q;
  logic         kv_q;

  logic [511:0] p1, p2;
  logic         p1v;
  logic [SW-1:0] p1k;

  logic [QW-1:0] c1_q, c2_q;
  logic [SW-1:0] kl_q;
  logic          cv_q;

  logic [319:0]  q_b1c1, q_a1c1, q_a1c2, q_a2c2;
  logic          qv;
  logic [SW-1:0] qk;

  logic [SW-1:0] k1_q, k2_q;
  logic          fv_q;

  logic          done_q;
  logic [127:0]  m1_q, m2_q;
  logic          n1_q, n2_q;

  assign busy_o = 1'b0;
  assign k_in   = {scalar_limb3_i, scalar_limb2_i, scalar_limb1_i, scalar_limb0_i};

  // one subtraction of n brings any 256-bit value below n
  always_ff @(posedge clk_i) begin
    if (k_in >= gss_pkg::OrderN) begin
      k_q <= k_in - gss_pkg::OrderN;
    end else begin
      k_q <= k_in;
    end
  end

  gss_mul #(.NA(8), .NB(8), .SW(SW)) u_mul_g1 (
    .clk_i, .rst_ni,
    .valid_i (kv_q),
    .a_i     (k_q),
    .b_i     (gss_pkg::G1),
    .side_i  (k_q[SW-1:0]),
    .valid_o (p1v),
    .prod_o  (p1),
    .side_o  (p1k)
  );

  gss_mul #(.NA(8), .NB(8), .SW(1)) u_mul_g2 (
    .clk_i, .rst_ni,
    .valid_i (kv_q),
    .a_i     (k_q),
    .b_i     (gss_pkg::G2),
    .side_i  (1'b0),
    .valid_o (),
    .prod_o  (p2),
    .side_o  ()
  );

  // round to nearest: add bit 383 into the top quarter
  always_ff @(posedge clk_i) begin
    c1_q <= QW'(p1[511:384]) + QW'(p1[383]);
    c2_q <= QW'(p2[511:384]) + QW'(p2[383]);
    kl_q <= p1k;
  end

  gss_mul #(.NA(5), .NB(5), .SW(SW)) u_mul_b1c1 (
    .clk_i, .rst_ni,
    .valid_i (cv_q),
    .a_i     (160'(c1_q)),
    .b_i     (160'(gss_pkg::MinusB1)),
    .side_i  (kl_q),
    .valid_o (qv),
    .prod_o  (q_b1c1),
    .side_o  (qk)
  );

  gss_mul #(.NA(5), .NB(5), .SW(1)) u_mul_a1c1 (
    .clk_i, .rst_ni,
    .valid_i (cv_q),
    .a_i     (160'(c1_q)),
    .b_i     (160'(gss_pkg::A1)),
    .side_i  (1'b0),
    .valid_o (),
    .prod_o  (q_a1c1),
    .side_o  ()
  );

  gss_mul #(.NA(5), .NB(5), .SW(1)) u_mul_a1c2 (
    .clk_i, .rst_ni,
    .valid_i (cv_q),
    .a_i     (160'(c2_q)),
    .b_i     (160'(gss_pkg::A1)),
    .side_i  (1'b0),
    .valid_o (),
    .prod_o  (q_a1c2),
    .side_o  ()
  );

  gss_mul #(.NA(5), .NB(5), .SW(1)) u_mul_a2c2 (
    .clk_i, .rst_ni,
    .valid_i (cv_q),
    .a_i     (160'(c2_q)),
    .b_i     (160'(gss_pkg::A2)),
    .side_i  (1'b0),
    .valid_o (),
    .prod_o  (q_a2c2),
    .side_o  ()
  );

  // halves are exact small integers, so two's complement mod 2^130 suffices:
  // k2 = c1*(-b1) - c2*a1, k1 = k - c1*a1 - c2*a2
  always_ff @(posedge clk_i) begin
    k2_q <= q_b1c1[SW-1:0] - q_a1c2[SW-1:0];
    k1_q <= qk - q_a1c1[SW-1:0] - q_a2c2[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    n1_q <= k1_q[SW-1];
    n2_q <= k2_q[SW-1];
    if (k1_q[SW-1]) begin
      m1_q <= 128'(SW'(0) - k1_q);
    end else begin
      m1_q <= k1_q[127:0];
    end
    if (k2_q[SW-1]) begin
      m2_q <= 128'(SW'(0) - k2_q);
    end else begin
      m2_q <= k2_q[127:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q   <= 1'b0;
      cv_q   <= 1'b0;
      fv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      kv_q   <= start_i;
      cv_q   <= p1v;
      fv_q   <= qv;
      done_q <= fv_q;
    end
  end

  assign done_o                 = done_q;
  assign first_half_low_o       = m1_q[63:0];
  assign first_half_high_o      = m1_q[127:64];
  assign first_half_negative_o  = n1_q;
  assign second_half_low_o      = m2_q[63:0];
  assign second_half_high_o     = m2_q[127:64];
  assign second_half_negative_o = n2_q;

endmodule
